// ===== rtl/fmsp_pkg.sv =====
// shared types, character codes and clause helpers for the mode string parser
`timescale 1ns / 1ps

package fmsp_pkg;

   // character codes
   localparam logic [7:0] CHR_U     = 8'h75;
   localparam logic [7:0] CHR_G     = 8'h67;
   localparam logic [7:0] CHR_O     = 8'h6F;
   localparam logic [7:0] CHR_A     = 8'h61;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_EQ    = 8'h3D;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_R     = 8'h72;
   localparam logic [7:0] CHR_W     = 8'h77;
   localparam logic [7:0] CHR_X     = 8'h78;
   localparam logic [7:0] CHR_XCAP  = 8'h58;
   localparam logic [7:0] CHR_S     = 8'h73;
   localparam logic [7:0] CHR_T     = 8'h74;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_SEVEN = 8'h37;

   localparam logic [11:0] PERM_MASK = 12'o7777;
   localparam logic [11:0] EXEC_ANY  = 12'o0111;
   localparam logic [11:0] STICKY    = 12'o1000;
   localparam logic [3:0]  TYPE_DIR  = 4'o04;

   // octal flag bits
   localparam int FLAG_NONDIGIT = 0;
   localparam int FLAG_OVERFLOW = 1;

   typedef enum logic [1:0] {
      PHASE_WHO  = 2'd0,
      PHASE_PERM = 2'd1
   } phase_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SET = 2'd2
   } op_type;

   // one request as seen by the parse units
   typedef struct packed {
      logic        valid;
      logic [7:0]  char_code;
      logic        first_char;
      logic        last_char;
      logic [15:0] old_mode;
   } step_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  who;
      op_type      op;
      logic [11:0] perm;
      logic        saw;
      logic [15:0] run;
      logic        x_ok;
      logic        err;
   } sym_state_type;

   function automatic logic [11:0] class_bits(logic [2:0] who, logic [11:0] u,
                                              logic [11:0] g, logic [11:0] o);
      logic [11:0] b;
      b = '0;
      if (who[0]) b = b | u;
      if (who[1]) b = b | g;
      if (who[2]) b = b | o;
      return b;
   endfunction

   function automatic sym_state_type start_clause(sym_state_type s, op_type op);
      sym_state_type r;
      r = s;
      if (s.who == 3'b000) r.who = 3'b111;
      r.op    = op;
      r.phase = PHASE_PERM;
      r.perm  = '0;
      r.saw   = 1'b0;
      return r;
   endfunction

   function automatic sym_state_type finish_clause(sym_state_type s);
      sym_state_type r;
      logic [11:0]   m;
      r = s;
      m = class_bits(s.who, 12'o4700, 12'o2070, 12'o1007);
      if (!s.saw && s.op != OP_SET) begin
         r.err = 1'b1;
      end else begin
         case (s.op)
            OP_ADD: r.run = s.run | {4'b0000, s.perm};
            OP_SUB: r.run = s.run & ~{4'b0000, s.perm};
            default: r.run = (s.run & ~{4'b0000, m}) | {4'b0000, s.perm};
         endcase
         r.phase = PHASE_WHO;
         r.who   = '0;
         r.op    = OP_ADD;
         r.perm  = '0;
         r.saw   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/fmsp_octal.sv =====
// octal digit parse: running value and flags, one character per cycle
`timescale 1ns / 1ps

module fmsp_octal (
   input  logic              clock,
   input  logic              reset,
   input  fmsp_pkg::step_type step,
   output logic [11:0]       value_next,
   output logic [1:0]        flags_next
);

   logic [11:0] value_ff;
   logic [11:0] value_in;
   logic [1:0]  flags_ff;
   logic [1:0]  flags_in;
   logic [11:0] value_cur;
   logic [1:0]  flags_cur;
   logic [2:0]  digit;

   always_comb begin
      value_cur = step.first_char ? 12'd0 : value_ff;
      flags_cur = step.first_char ? 2'b00 : flags_ff;
      digit     = step.char_code[2:0];
      value_next = value_cur;
      flags_next = flags_cur;
      if (step.char_code >= fmsp_pkg::CHR_ZERO && step.char_code <= fmsp_pkg::CHR_SEVEN) begin
         // value times eight exceeds the limit when any top digit bit is set
         if (value_cur[11:9] != 3'b000) flags_next[fmsp_pkg::FLAG_OVERFLOW] = 1'b1;
         value_next = {value_cur[8:0], digit};
      end else begin
         flags_next[fmsp_pkg::FLAG_NONDIGIT] = 1'b1;
      end
      value_in = step.valid ? value_next : value_ff;
      flags_in = step.valid ? flags_next : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         flags_ff <= '0;
      end else begin
         value_ff <= value_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// ===== rtl/fmsp_symbolic.sv =====
// symbolic clause parse: who letters, operator, permission letters
`timescale 1ns / 1ps

module fmsp_symbolic (
   input  logic              clock,
   input  logic              reset,
   input  fmsp_pkg::step_type step,
   output logic [15:0]       run_mode,
   output logic              sym_err
);

   fmsp_pkg::sym_state_type state_ff;
   fmsp_pkg::sym_state_type state_in;
   fmsp_pkg::sym_state_type cur;
   fmsp_pkg::sym_state_type nxt;
   fmsp_pkg::sym_state_type fin;
   logic [11:0]             xbits;

   always_comb begin
      cur = state_ff;
      if (step.first_char) begin
         cur       = '0;
         cur.phase = fmsp_pkg::PHASE_WHO;
         cur.op    = fmsp_pkg::OP_ADD;
         cur.run   = step.old_mode;
         cur.x_ok  = (step.old_mode[15:12] == fmsp_pkg::TYPE_DIR) ||
                     ((step.old_mode[11:0] & fmsp_pkg::EXEC_ANY) != 12'd0);
      end
      xbits = fmsp_pkg::class_bits(cur.who, 12'o0100, 12'o0010, 12'o0001);
      nxt = cur;
      if (!cur.err) begin
         if (cur.phase == fmsp_pkg::PHASE_WHO) begin
            case (step.char_code)
               fmsp_pkg::CHR_U:     nxt.who = cur.who | 3'b001;
               fmsp_pkg::CHR_G:     nxt.who = cur.who | 3'b010;
               fmsp_pkg::CHR_O:     nxt.who = cur.who | 3'b100;
               fmsp_pkg::CHR_A:     nxt.who = 3'b111;
               fmsp_pkg::CHR_PLUS:  nxt = fmsp_pkg::start_clause(cur, fmsp_pkg::OP_ADD);
               fmsp_pkg::CHR_MINUS: nxt = fmsp_pkg::start_clause(cur, fmsp_pkg::OP_SUB);
               fmsp_pkg::CHR_EQ:    nxt = fmsp_pkg::start_clause(cur, fmsp_pkg::OP_SET);
               default:             nxt.err = 1'b1;
            endcase
         end else if (step.char_code == fmsp_pkg::CHR_COMMA) begin
            nxt = fmsp_pkg::finish_clause(cur);
         end else begin
            nxt.saw = 1'b1;
            case (step.char_code)
               fmsp_pkg::CHR_R: nxt.perm = cur.perm |
                  fmsp_pkg::class_bits(cur.who, 12'o0400, 12'o0040, 12'o0004);
               fmsp_pkg::CHR_W: nxt.perm = cur.perm |
                  fmsp_pkg::class_bits(cur.who, 12'o0200, 12'o0020, 12'o0002);
               fmsp_pkg::CHR_X: nxt.perm = cur.perm | xbits;
               // conditional execute: only for directories or already executable files
               fmsp_pkg::CHR_XCAP: nxt.perm = cur.x_ok ? (cur.perm | xbits) : cur.perm;
               fmsp_pkg::CHR_S: nxt.perm = cur.perm |
                  fmsp_pkg::class_bits(cur.who, 12'o4000, 12'o2000, 12'o0000);
               fmsp_pkg::CHR_T: nxt.perm = cur.perm |
                  fmsp_pkg::class_bits(cur.who, 12'o0000, 12'o0000, fmsp_pkg::STICKY);
               default: nxt.err = 1'b1;
            endcase
         end
      end
      // end of string closes an open clause; dangling who letters are an error
      fin = nxt;
      if (step.last_char && !nxt.err) begin
         if (nxt.phase == fmsp_pkg::PHASE_PERM) fin = fmsp_pkg::finish_clause(nxt);
         else if (nxt.who != 3'b000) fin.err = 1'b1;
      end
      run_mode = fin.run;
      sym_err  = fin.err;
      state_in = step.valid ? fin : state_ff;
   end

   // all zero is the who letters phase with operator plus
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/file_mode_string_parser.sv =====
// top level of the mode string parser: request register, parse units, result register
`timescale 1ns / 1ps

//  channel   direction  ports
//  req       in         req_valid, req_stall, req_char_code, req_first_char,
//                       req_last_char, req_old_mode
//  rsp       out        rsp_valid, rsp_stall, rsp_new_mode, rsp_status
//
//  one character per cycle while req_stall is low; a result becomes valid in the result register
//  once its last character advances out of the request register; the octal and symbolic parse
//  states are updated as a character advances out of the request register, and that update sets the rate
//  reset clears all parse state, as if a first character had come with mode zero
//  req_stall rises only while a last character waits behind a stalled result

module file_mode_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_first_char,
   input  logic        req_last_char,
   input  logic [15:0] req_old_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_new_mode,
   output logic        rsp_status
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_char_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   logic [15:0]       in_old_ff;
   logic              advance;
   fmsp_pkg::step_type step;
   logic [11:0]       oct_value;
   logic [1:0]        oct_flags;
   logic [15:0]       run_mode;
   logic              sym_err;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [15:0]       rsp_mode_ff;
   logic [15:0]       rsp_mode_in;
   logic              rsp_status_ff;
   logic              rsp_status_in;

   // a non-last character never waits on the result side
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      step.valid      = advance;
      step.char_code  = in_char_ff;
      step.first_char = in_first_ff;
      step.last_char  = in_last_ff;
      step.old_mode   = in_old_ff;
   end

   fmsp_octal u_octal (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .value_next (oct_value),
      .flags_next (oct_flags)
   );

   fmsp_symbolic u_symbolic (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .run_mode (run_mode),
      .sym_err  (sym_err)
   );

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      if (oct_flags == 2'b00) begin
         rsp_mode_in   = {4'b0000, oct_value};
         rsp_status_in = 1'b0;
      end else if (!sym_err) begin
         rsp_mode_in   = run_mode;
         rsp_status_in = 1'b0;
      end else begin
         rsp_mode_in   = '0;
         rsp_status_in = 1'b1;
      end
      if (advance && in_last_ff) rsp_valid_in = 1'b1;
      else if (!rsp_stall)       rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (!req_stall) begin
         in_char_ff  <= req_char_code;
         in_first_ff <= req_first_char;
         in_last_ff  <= req_last_char;
         in_old_ff   <= req_old_mode;
      end
      if (advance && in_last_ff) begin
         rsp_mode_ff   <= rsp_mode_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_new_mode = rsp_mode_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== rtl/fmsp_checker.sv =====
// port checks for the mode string parser, bound to the top level
`timescale 1ns / 1ps

module fmsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_new_mode,
   input logic        rsp_status
);

   // a waiting result is not dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a waiting result does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_mode) && $stable(rsp_status))
      else $error("result changed while stalled");

   // an invalid string reports mode zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_new_mode == 16'd0)
      else $error("invalid status with nonzero mode");

   // requests back up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result back pressure");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind file_mode_string_parser fmsp_checker u_fmsp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_new_mode (rsp_new_mode),
   .rsp_status   (rsp_status)
);

// ===== dv/file_mode_string_parser_tb.sv =====
// testbench for the mode string parser: directed and random mode strings checked per result
`timescale 1ns / 1ps

module file_mode_string_parser_tb;

   localparam int RANDOM_CHARS = 1750;
   localparam int SEND_QUIET_LO = 600;    // requests sent with no sender idling
   localparam int SEND_QUIET_HI = 900;
   localparam int PAUSE_AT = 1200;        // sender waits here until every result is back
   localparam int RECV_QUIET_LO = 150;    // results checked with no receiver stalls
   localparam int RECV_QUIET_HI = 200;
   localparam int HOLD_AT = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS = 10;
   localparam logic [3:0] TYPE_REG = 4'o10;

   typedef logic [7:0] char_list_type[$];

   typedef struct packed {
      logic [7:0]  char_code;
      logic        first_char;
      logic        last_char;
      logic [15:0] old_mode;
   } mode_char_type;

   typedef struct packed {
      logic [15:0] new_mode;
      logic        status;
   } mode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = '0;
   logic        req_first_char = 1'b0;
   logic        req_last_char = 1'b0;
   logic [15:0] req_old_mode = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_new_mode;
   logic        rsp_status;

   file_mode_string_parser uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_first_char (req_first_char),
      .req_last_char  (req_last_char),
      .req_old_mode   (req_old_mode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_new_mode   (rsp_new_mode),
      .rsp_status     (rsp_status)
   );

   mode_char_type   char_q[$];
   mode_result_type mode_results_q[$];
   int unsigned     chars_sent = 0;
   int unsigned     results_issued = 0;
   int unsigned     results_checked = 0;
   int unsigned     mismatches = 0;
   logic            hold_active = 1'b0;
   bit              hold_done = 1'b0;
   int              hold_left = 0;

   // parse state
   fmsp_pkg::phase_type sym_phase;
   logic [2:0]          sym_who;
   fmsp_pkg::op_type    sym_op;
   logic [11:0]         sym_perm;
   logic                sym_saw;
   logic                sym_err;
   logic [15:0]         edit_mode;
   logic [15:0]         sampled_mode;
   logic [11:0]         oct_value;
   logic                oct_nondigit;
   logic                oct_overflow;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [11:0] who_select(logic [11:0] u, logic [11:0] g, logic [11:0] o);
      logic [11:0] b;
      b = '0;
      if (sym_who[0]) b |= u;
      if (sym_who[1]) b |= g;
      if (sym_who[2]) b |= o;
      return b;
   endfunction

   task automatic restart_parse(input logic [15:0] old);
      sym_phase = fmsp_pkg::PHASE_WHO;
      sym_who = '0;
      sym_op = fmsp_pkg::OP_ADD;
      sym_perm = '0;
      sym_saw = 1'b0;
      sym_err = 1'b0;
      edit_mode = old;
      sampled_mode = old;
      oct_value = '0;
      oct_nondigit = 1'b0;
      oct_overflow = 1'b0;
   endtask

   task automatic close_clause();
      logic [11:0] m;
      m = who_select(12'o4700, 12'o2070, 12'o1007);
      if (!sym_saw && sym_op != fmsp_pkg::OP_SET) begin
         sym_err = 1'b1;
      end else begin
         case (sym_op)
            fmsp_pkg::OP_ADD: edit_mode[11:0] = edit_mode[11:0] | sym_perm;
            fmsp_pkg::OP_SUB: edit_mode[11:0] = edit_mode[11:0] & ~sym_perm;
            default: edit_mode[11:0] = (edit_mode[11:0] & ~m) | sym_perm;
         endcase
         sym_phase = fmsp_pkg::PHASE_WHO;
         sym_who = '0;
         sym_op = fmsp_pkg::OP_ADD;
         sym_perm = '0;
         sym_saw = 1'b0;
      end
   endtask

   task automatic parse_mode_char(input mode_char_type it, output bit has_result,
                                  output mode_result_type res);
      logic [7:0]  c;
      logic [14:0] nv;
      c = it.char_code;
      if (it.first_char) restart_parse(it.old_mode);

      if (c >= fmsp_pkg::CHR_ZERO && c <= fmsp_pkg::CHR_SEVEN) begin
         nv = {oct_value, 3'b000} + 15'(c - fmsp_pkg::CHR_ZERO);
         if (nv > 15'o7777) oct_overflow = 1'b1;
         oct_value = nv[11:0];
      end else begin
         oct_nondigit = 1'b1;
      end

      if (!sym_err) begin
         if (sym_phase == fmsp_pkg::PHASE_WHO) begin
            case (c)
               fmsp_pkg::CHR_U: sym_who |= 3'b001;
               fmsp_pkg::CHR_G: sym_who |= 3'b010;
               fmsp_pkg::CHR_O: sym_who |= 3'b100;
               fmsp_pkg::CHR_A: sym_who = 3'b111;
               fmsp_pkg::CHR_PLUS, fmsp_pkg::CHR_MINUS, fmsp_pkg::CHR_EQ: begin
                  if (sym_who == 3'b000) sym_who = 3'b111;
                  sym_op = (c == fmsp_pkg::CHR_PLUS)  ? fmsp_pkg::OP_ADD :
                           (c == fmsp_pkg::CHR_MINUS) ? fmsp_pkg::OP_SUB : fmsp_pkg::OP_SET;
                  sym_phase = fmsp_pkg::PHASE_PERM;
                  sym_perm = '0;
                  sym_saw = 1'b0;
               end
               default: sym_err = 1'b1;
            endcase
         end else if (c == fmsp_pkg::CHR_COMMA) begin
            close_clause();
         end else begin
            sym_saw = 1'b1;
            case (c)
               fmsp_pkg::CHR_R: sym_perm |= who_select(12'o0400, 12'o0040, 12'o0004);
               fmsp_pkg::CHR_W: sym_perm |= who_select(12'o0200, 12'o0020, 12'o0002);
               fmsp_pkg::CHR_X: sym_perm |= who_select(12'o0100, 12'o0010, 12'o0001);
               fmsp_pkg::CHR_XCAP: begin
                  // only for directories or modes that already have some execute bit
                  if (sampled_mode[15:12] == fmsp_pkg::TYPE_DIR ||
                      (sampled_mode[11:0] & fmsp_pkg::EXEC_ANY) != '0)
                     sym_perm |= who_select(12'o0100, 12'o0010, 12'o0001);
               end
               fmsp_pkg::CHR_S: sym_perm |= who_select(12'o4000, 12'o2000, 12'o0000);
               fmsp_pkg::CHR_T: sym_perm |= who_select(12'o0000, 12'o0000, fmsp_pkg::STICKY);
               default: sym_err = 1'b1;
            endcase
         end
      end

      has_result = it.last_char;
      res = '0;
      if (it.last_char) begin
         if (!sym_err) begin
            if (sym_phase == fmsp_pkg::PHASE_PERM) close_clause();
            else if (sym_who != 3'b000) sym_err = 1'b1;
         end
         if (!oct_nondigit && !oct_overflow) begin
            res.new_mode = {4'b0000, oct_value};
         end else if (!sym_err) begin
            res.new_mode = edit_mode;
         end else begin
            res.status = 1'b1;
         end
      end
   endtask

   task automatic add_string(input char_list_type s, input logic [15:0] old,
                             input bit mark_first);
      mode_char_type it;
      foreach (s[i]) begin
         it.char_code = s[i];
         // a rare restart in the middle of a string
         it.first_char = (i == 0) ? mark_first : ($urandom_range(49) == 0);
         it.last_char = (i == s.size() - 1);
         it.old_mode = (i == 0) ? old : 16'($urandom);
         char_q.push_back(it);
      end
   endtask

   function automatic logic [15:0] random_old_mode();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return {fmsp_pkg::TYPE_DIR, 12'($urandom)};
         2: return {TYPE_REG, 12'($urandom) & ~fmsp_pkg::EXEC_ANY};
         default: return {TYPE_REG, 12'($urandom)};
      endcase
   endfunction

   task automatic add_random_string();
      char_list_type s;
      logic [7:0] who_chars[4];
      logic [7:0] op_chars[3];
      logic [7:0] perm_chars[6];
      int kind;
      int n;
      int k;
      who_chars = '{fmsp_pkg::CHR_U, fmsp_pkg::CHR_G, fmsp_pkg::CHR_O, fmsp_pkg::CHR_A};
      op_chars = '{fmsp_pkg::CHR_PLUS, fmsp_pkg::CHR_MINUS, fmsp_pkg::CHR_EQ};
      perm_chars = '{fmsp_pkg::CHR_R, fmsp_pkg::CHR_W, fmsp_pkg::CHR_X,
                     fmsp_pkg::CHR_XCAP, fmsp_pkg::CHR_S, fmsp_pkg::CHR_T};
      kind = $urandom_range(99);
      if (kind < 60) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            if (i != 0) s.push_back(fmsp_pkg::CHR_COMMA);
            k = $urandom_range(2);
            repeat (k) s.push_back(who_chars[$urandom_range(3)]);
            s.push_back(op_chars[$urandom_range(2)]);
            k = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            repeat (k) s.push_back(perm_chars[$urandom_range(5)]);
         end
         if ($urandom_range(9) == 0) s.push_back(fmsp_pkg::CHR_COMMA);
      end else if (kind < 80) begin
         n = $urandom_range(1, 5);
         repeat (n) s.push_back(fmsp_pkg::CHR_ZERO + 8'($urandom_range(7)));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) s.push_back(8'($urandom_range(255)));
      end
      // broken strings: a stray byte or a cut tail
      if (kind < 80 && $urandom_range(99) < 15) begin
         if ($urandom_range(1) == 1) s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
         else s = s[0:$urandom_range(s.size() - 1)];
      end
      add_string(s, random_old_mode(), $urandom_range(9) != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      bit              has_res;
      mode_result_type res;
      bit              offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_mode_char({req_char_code, req_first_char, req_last_char, req_old_mode},
                            has_res, res);
            if (has_res) begin
               mode_results_q.push_back(res);
               results_issued <= results_issued + 1;
            end
            chars_sent++;
         end
         if (!req_valid || !req_stall) begin
            offer = (char_q.size() != 0);
            if (chars_sent == PAUSE_AT && mode_results_q.size() != 0) offer = 1'b0;
            if (!(chars_sent >= SEND_QUIET_LO && chars_sent < SEND_QUIET_HI)
                && $urandom_range(99) < 28) offer = 1'b0;
            if (offer) begin
               req_char_code <= char_q[0].char_code;
               req_first_char <= char_q[0].first_char;
               req_last_char <= char_q[0].last_char;
               req_old_mode <= char_q[0].old_mode;
               void'(char_q.pop_front());
            end
            req_valid <= offer;
         end
      end
   end

   // long receiver hold-off once some results have come back
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_left <= 0;
      end else if (!hold_done && results_checked >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_active <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         hold_active <= (hold_left > 1);
      end
   end

   // result monitor
   always @(posedge clock) begin
      mode_result_type want;
      bit              quiet;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            // only requests accepted at earlier edges can have a result now
            if (results_issued == results_checked) begin
               if (mismatches < MAX_REPORTS)
                  $display("unexpected result: new_mode %o status %0d", rsp_new_mode, rsp_status);
               mismatches++;
            end else begin
               want = mode_results_q.pop_front();
               if (rsp_new_mode !== want.new_mode || rsp_status !== want.status) begin
                  if (mismatches < MAX_REPORTS)
                     $display("result %0d: new_mode exp %o got %o, status exp %0d got %0d",
                              results_checked, want.new_mode, rsp_new_mode,
                              want.status, rsp_status);
                  mismatches++;
               end
               results_checked++;
            end
         end
         quiet = (results_checked >= RECV_QUIET_LO && results_checked < RECV_QUIET_HI);
         rsp_stall <= hold_active || (!quiet && $urandom_range(99) < 28);
      end
   end

   initial begin
      restart_parse('0);

      // first string runs against the reset state, no first mark
      add_string('{fmsp_pkg::CHR_SEVEN, fmsp_pkg::CHR_SEVEN, fmsp_pkg::CHR_SEVEN,
                   fmsp_pkg::CHR_SEVEN}, 16'hFFFF, 1'b0);
      add_string('{fmsp_pkg::CHR_EQ}, 16'hFFFF, 1'b1);
      add_string('{fmsp_pkg::CHR_PLUS}, 16'h1234, 1'b1);
      add_string('{fmsp_pkg::CHR_U}, 16'o100644, 1'b1);
      add_string('{fmsp_pkg::CHR_A, fmsp_pkg::CHR_PLUS, fmsp_pkg::CHR_XCAP,
                   fmsp_pkg::CHR_COMMA}, {fmsp_pkg::TYPE_DIR, 12'o0000}, 1'b1);
      add_string('{fmsp_pkg::CHR_U, fmsp_pkg::CHR_PLUS, fmsp_pkg::CHR_XCAP},
                 {TYPE_REG, 12'o0644}, 1'b1);
      add_string('{fmsp_pkg::CHR_U, fmsp_pkg::CHR_G, fmsp_pkg::CHR_EQ, fmsp_pkg::CHR_S,
                   fmsp_pkg::CHR_R, fmsp_pkg::CHR_COMMA, fmsp_pkg::CHR_O,
                   fmsp_pkg::CHR_PLUS, fmsp_pkg::CHR_T}, 16'h0000, 1'b1);
      add_string('{8'h00}, 16'h0000, 1'b1);
      add_string('{8'hFF}, 16'hFFFF, 1'b1);
      while (char_q.size() < RANDOM_CHARS + 25) add_random_string();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_valid || mode_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
